/* hdl/mnva_pkg.sv */
// ----------------------------------------------------------------------------
// mnva_pkg
// types, constants and codes shared by the midi note voice allocator files
// ----------------------------------------------------------------------------
`default_nettype none

package mnva_pkg;

	// number of voices and the width of a voice counter
	localparam int VOICES = 4;
	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

	// midi message constants
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

	// frame header kinds and gate level
	localparam logic [3:0]  HDR_PITCH   = 4'h3;
	localparam logic [3:0]  HDR_GATE    = 4'hF;
	localparam logic [23:0] GATE_ON     = 24'hFFFFFF;
	localparam logic [16:0] CENTER_BEND = 17'h10000;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// byte assembly counts
	localparam logic [1:0] CNT_NONE   = 2'd0;
	localparam logic [1:0] CNT_STATUS = 2'd1;
	localparam logic [1:0] CNT_DATA1  = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  voice_index;
		logic [31:0] pitch_frame;
		logic [31:0] gate_frame;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic {
		OP_START,
		OP_STOP
	} op_t;

endpackage

`default_nettype wire

/* hdl/midi_note_voice_allocator.sv */
// A midi byte item is taken while the block is idle; a completed Note On/Off
// message then scans the voices through one shared compare.
// A tick gives its first result the cycle after it is taken and one
// result per cycle (VOICES results) while out_ready is high; in_ready returns
// once the last result is taken. Reset (arst_n low) frees every voice and
// closes any open message.
// ----------------------------------------------------------------------------
// midi_note_voice_allocator
// assembles midi note messages into voice claims and releases, and emits
// pitch and gate frames for every voice on each refresh tick
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_voice_allocator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mnva_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mnva_pkg::out_item_t       out_data
);
	import mnva_pkg::*;

	state_t              state_q, state_d;
	op_t                 op_q;
	logic [7:0]          status_byte_q;
	logic [6:0]          first_data_q;
	logic [1:0]          byte_cnt_q;
	logic [VIDX_W-1:0]   vcnt_q;
	logic [VOICES-1:0]   voice_active_q;
	logic [6:0]          voice_note_q [VOICES];

	logic                in_acc;
	logic                out_acc;
	logic                is_last;
	logic                cur_active;
	logic                cur_hit;
	logic                msg_go;
	logic                cnt_clr;
	logic                cnt_inc;
	logic                claim_en;
	logic                clear_en;
	logic [VIDX_W-1:0]   wr_idx;
	logic [6:0]          cur_note;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign is_last = (vcnt_q == VIDX_W'(VOICES - 1));

	// shared compare on the voice under the counter
	assign cur_active = voice_active_q[vcnt_q];
	assign cur_hit    = cur_active && (voice_note_q[vcnt_q] == first_data_q);

	// second data byte of a note on or note off message
	assign msg_go = in_acc && (in_data.kind == KIND_BYTE) && !in_data.rx_byte[7]
		&& (byte_cnt_q == CNT_DATA1)
		&& ((status_byte_q[7:4] == CMD_NOTE_ON) || (status_byte_q[7:4] == CMD_NOTE_OFF));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		claim_en  = 1'b0;
		clear_en  = 1'b0;
		wr_idx    = vcnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_acc && (in_data.kind == KIND_TICK)) begin
					state_d = ST_EMIT;
					cnt_clr = 1'b1;
				end else if (msg_go) begin
					state_d = ST_SCAN;
					cnt_clr = 1'b1;
				end
			end
			ST_SCAN: begin
				if (op_q == OP_START) begin
					if (!cur_active) begin
						claim_en = 1'b1;
						state_d  = ST_IDLE;
					end else if (is_last) begin
						// every voice busy: steal voice 0
						claim_en = 1'b1;
						wr_idx   = '0;
						state_d  = ST_IDLE;
					end else begin
						cnt_inc = 1'b1;
					end
				end else begin
					if (cur_hit) begin
						clear_en = 1'b1;
						state_d  = ST_IDLE;
					end else if (is_last) begin
						state_d = ST_IDLE;
					end else begin
						cnt_inc = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_acc) begin
					if (is_last) begin
						state_d = ST_IDLE;
					end else begin
						cnt_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// message assembly and voice counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_byte_q  <= '0;
			first_data_q   <= '0;
			byte_cnt_q     <= CNT_NONE;
			vcnt_q         <= '0;
			op_q           <= OP_START;
			voice_active_q <= '0;
		end else begin
			if (in_acc && (in_data.kind == KIND_BYTE)) begin
				if (in_data.rx_byte[7]) begin
					status_byte_q <= in_data.rx_byte;
					byte_cnt_q    <= CNT_STATUS;
				end else if (byte_cnt_q == CNT_STATUS) begin
					first_data_q <= in_data.rx_byte[6:0];
					byte_cnt_q   <= CNT_DATA1;
				end else if (byte_cnt_q == CNT_DATA1) begin
					byte_cnt_q <= CNT_NONE;
				end
			end
			if (msg_go) begin
				// note on with zero velocity releases like note off
				if ((status_byte_q[7:4] == CMD_NOTE_ON) && (in_data.rx_byte[6:0] != 7'd0)) begin
					op_q <= OP_START;
				end else begin
					op_q <= OP_STOP;
				end
			end
			if (cnt_clr) begin
				vcnt_q <= '0;
			end else if (cnt_inc) begin
				vcnt_q <= vcnt_q + 1'b1;
			end
			if (claim_en) begin
				voice_active_q[wr_idx] <= 1'b1;
			end else if (clear_en) begin
				voice_active_q[wr_idx] <= 1'b0;
			end
		end
	end

	// voice notes
	always_ff @(posedge clk) begin
		if (claim_en) begin
			voice_note_q[wr_idx] <= first_data_q;
		end
	end

	// result frames for the voice under the counter
	assign cur_note = cur_active ? voice_note_q[vcnt_q] : 7'd0;

	always_comb begin
		out_data.voice_index = 2'(vcnt_q);
		out_data.pitch_frame = {1'b1, 3'(vcnt_q), HDR_PITCH, cur_note, CENTER_BEND};
		out_data.gate_frame  = {1'b1, 3'(vcnt_q), HDR_GATE, cur_active ? GATE_ON : 24'd0};
		out_data.last        = is_last;
	end

endmodule

`default_nettype wire

/* hdl/mnva_checker.sv */
// ----------------------------------------------------------------------------
// mnva_checker
// port-level checks on the voice allocator's result sequence
// ----------------------------------------------------------------------------
`default_nettype none

module mnva_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire mnva_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire mnva_pkg::out_item_t out_data
);
	import mnva_pkg::*;

	// no new item is taken while results are pending
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while results pending");

	// a tick starts its results with voice 0
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.kind == KIND_TICK))
		|=> (out_valid && (out_data.voice_index == 2'd0)))
		else $error("tick did not start at voice 0");

	// results follow one voice after another
	a_next_voice: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_data.last)
		|=> (out_valid && (out_data.voice_index == 2'($past(out_data.voice_index) + 2'd1))))
		else $error("voice sequence broken");

	// nothing follows the final voice
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last) |=> !out_valid)
		else $error("result after final voice");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind midi_note_voice_allocator mnva_checker u_mnva_checker (.*);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives midi bytes and refresh ticks into the voice allocator, keeps its own
// copy of the message assembly and voice table, and checks every voice frame
// that comes back against it, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------

module tb;
	import mnva_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 2 * VOICES + 20;
	localparam int HOLD_CYCLES = 500;
	localparam int HOLD_AFTER  = 40;

	// voice table tracker and store of frames still due
	class voice_board;
		logic [7:0] status;
		logic [6:0] first_data;
		logic [1:0] count;
		bit         voice_on[VOICES];
		logic [6:0] voice_pitch[VOICES];
		out_item_t  frames_due[$];
		int         errors, checked, bytes_seen, ticks_seen;
		int         claims, steals, releases;

		function new();
			status     = '0;
			first_data = '0;
			count      = CNT_NONE;
			for (int v = 0; v < VOICES; v++) begin
				voice_on[v]    = 1'b0;
				voice_pitch[v] = '0;
			end
		endfunction

		// lowest free voice, or voice 0 when every voice is busy
		function void claim_voice(logic [6:0] note);
			int pick;
			pick = -1;
			for (int v = 0; v < VOICES; v++)
				if (!voice_on[v] && pick < 0) pick = v;
			if (pick < 0) begin
				pick = 0;
				steals++;
			end
			voice_on[pick]    = 1'b1;
			voice_pitch[pick] = note;
			claims++;
		endfunction

		// lowest active voice holding the note goes free
		function void free_voice(logic [6:0] note);
			for (int v = 0; v < VOICES; v++) begin
				if (voice_on[v] && voice_pitch[v] == note) begin
					voice_on[v] = 1'b0;
					releases++;
					return;
				end
			end
		endfunction

		function void note_item(in_item_t it);
			out_item_t f;
			if (it.kind == KIND_TICK) begin
				// one frame pair per voice, state untouched
				ticks_seen++;
				for (int v = 0; v < VOICES; v++) begin
					f.voice_index = 2'(v);
					f.pitch_frame = {1'b1, 3'(v), HDR_PITCH,
						voice_on[v] ? voice_pitch[v] : 7'd0, CENTER_BEND};
					f.gate_frame  = {1'b1, 3'(v), HDR_GATE,
						voice_on[v] ? GATE_ON : 24'd0};
					f.last        = (v == VOICES - 1);
					frames_due.push_back(f);
				end
				return;
			end
			bytes_seen++;
			// message assembly, no running status
			if (it.rx_byte[7]) begin
				status = it.rx_byte;
				count  = CNT_STATUS;
			end else if (count == CNT_STATUS) begin
				first_data = it.rx_byte[6:0];
				count      = CNT_DATA1;
			end else if (count == CNT_DATA1) begin
				if (status[7:4] == CMD_NOTE_ON) begin
					if (it.rx_byte[6:0] != 7'd0) claim_voice(first_data);
					else free_voice(first_data);
				end else if (status[7:4] == CMD_NOTE_OFF) begin
					free_voice(first_data);
				end
				count = CNT_NONE;
			end
		endfunction

		function void check_frame(out_item_t got);
			out_item_t want;
			if (frames_due.size() == 0) begin
				$error("unexpected frame for voice %0d", got.voice_index);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			checked++;
			if (got.voice_index !== want.voice_index) begin
				$error("voice_index: expected %0d, got %0d", want.voice_index,
					got.voice_index);
				errors++;
			end
			if (got.pitch_frame !== want.pitch_frame) begin
				$error("pitch_frame: expected %h, got %h", want.pitch_frame,
					got.pitch_frame);
				errors++;
			end
			if (got.gate_frame !== want.gate_frame) begin
				$error("gate_frame: expected %h, got %h", want.gate_frame,
					got.gate_frame);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	bit         steady       = 1'b0;
	int         frames_taken = 0;
	int         idle_cycles  = 0;
	voice_board board;
	in_item_t   items_to_send[$];

	midi_note_voice_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		in_item_t it;
		it.kind    = KIND_BYTE;
		it.rx_byte = b;
		items_to_send.push_back(it);
	endtask

	task automatic push_tick(input logic [7:0] b);
		in_item_t it;
		it.kind    = KIND_TICK;
		it.rx_byte = b;
		items_to_send.push_back(it);
	endtask

	task automatic push_message(input logic [7:0] st, input logic [7:0] d1,
			input logic [7:0] d2);
		push_byte(st);
		push_byte(d1);
		push_byte(d2);
	endtask

	// directed part: extremes, stealing, both release paths, ignored traffic
	task automatic plan_directed();
		push_tick(8'hFF);
		push_message({CMD_NOTE_ON, 4'h0}, 8'h00, 8'h7F);
		push_message({CMD_NOTE_ON, 4'hF}, 8'h7F, 8'h01);
		push_message({CMD_NOTE_ON, 4'h5}, 8'h3C, 8'h40);
		// same note again takes another voice
		push_message({CMD_NOTE_ON, 4'h5}, 8'h3C, 8'h40);
		// every voice busy, voice 0 is taken over
		push_message({CMD_NOTE_ON, 4'h0}, 8'h55, 8'h22);
		// data byte after a completed message
		push_byte(8'h7F);
		push_tick(8'h00);
		push_message({CMD_NOTE_OFF, 4'h3}, 8'h3C, 8'h00);
		// note on with zero velocity releases
		push_message({CMD_NOTE_ON, 4'h0}, 8'h7F, 8'h00);
		// note off for a note that is not sounding
		push_message({CMD_NOTE_OFF, 4'hA}, 8'h11, 8'h22);
		// control change on a held note does nothing
		push_message(8'hB0, 8'h3C, 8'h00);
		push_tick(8'h5A);
	endtask

	// random part: mostly well-formed note traffic, some noise
	task automatic plan_random();
		int         useful;
		int         r;
		logic [6:0] note;
		useful = 0;
		while (useful < 390) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 3) != 0) note = 7'(48 + $urandom_range(0, 7));
			else note = 7'($urandom_range(0, 127));
			if (r < 25) begin
				push_tick(8'($urandom));
				useful++;
			end else if (r < 55) begin
				push_message({CMD_NOTE_ON, 4'($urandom)}, {1'b0, note},
					($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
				useful += 3;
			end else if (r < 80) begin
				push_message({CMD_NOTE_OFF, 4'($urandom)}, {1'b0, note},
					8'($urandom_range(0, 127)));
				useful += 3;
			end else if (r < 88) begin
				// other commands, system and real-time bytes
				push_message(8'($urandom_range(8'hA0, 8'hFF)), {1'b0, note},
					8'($urandom_range(0, 127)));
			end else if (r < 94) begin
				// message cut short by the next status byte
				push_byte({CMD_NOTE_ON, 4'($urandom)});
				push_byte({1'b0, note});
			end else begin
				push_byte(8'($urandom));
			end
		end
	endtask

	// offer one item and hold it until taken
	task automatic send_item(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// handshake monitors
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_item(in_data);
		if (arst_n && out_valid && out_ready) begin
			board.check_frame(out_data);
			frames_taken++;
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	initial begin : receiver
		int stall;
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && frames_taken >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// sender and end of run
	initial begin : main
		board = new();
		plan_directed();
		plan_random();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (items_to_send[i]) begin
			steady = (i % 160) >= 120;
			send_item(items_to_send[i]);
		end
		in_valid <= 1'b0;
		steady = 1'b0;
		// let the monitor book the final item first
		@(posedge clk);
		while (board.frames_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d midi bytes and %0d ticks, checked %0d voice frames",
			board.bytes_seen, board.ticks_seen, board.checked);
		$display("voice claims %0d (%0d taken over from a busy voice), releases %0d",
			board.claims, board.steals, board.releases);
		if (board.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
